FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms used by the TLB top level.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/stlb_pkg.sv
// ----------------------------------------------------------------------------
// stlb_pkg
// Request kind, request, result, status and state types and fixed constants of the TLB.
// ----------------------------------------------------------------------------
package stlb_pkg;

    localparam int KIND_W   = 2;
    localparam int VADDR_W  = 32;
    localparam int PFRAME_W = 16;
    localparam int TID_W    = 8;
    localparam int PNUM_W   = 25;
    localparam int PHYS_W   = 23;
    localparam int AGE_W    = 16;

    localparam logic [AGE_W-1:0] AGE_MAX = '1;

    typedef enum logic [KIND_W-1:0] {
        KIND_TRANSLATE  = 2'd0,
        KIND_INSERT     = 2'd1,
        KIND_INVALIDATE = 2'd2
    } stlb_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } stlb_state_t;

    typedef struct packed {
        stlb_kind_t            kind;
        logic [VADDR_W-1:0]    virt_addr;
        logic [PFRAME_W-1:0]   page_frame;
        logic [TID_W-1:0]      thread_id;
        logic [PNUM_W-1:0]     page_number;
    } stlb_req_t;

    typedef struct packed {
        logic                  hit;
        logic [PHYS_W-1:0]     phys_addr;
        logic                  replaced;
    } stlb_rsp_t;

    typedef struct packed {
        logic                  hit;
        logic                  replaced;
        logic                  row_we;
    } stlb_status_t;

endpackage

FILE: hdl/stlb_row_ram.sv
// ----------------------------------------------------------------------------
// stlb_row_ram
// Synchronous memory holding one row per set, one write and one read port.
// ----------------------------------------------------------------------------
module stlb_row_ram #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 252
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hdl/stlb_set_logic.sv
// ----------------------------------------------------------------------------
// stlb_set_logic
// Lookup, replacement choice and invalidation over the ways of one set row.
// ----------------------------------------------------------------------------
module stlb_set_logic #(
    parameter int NUM_WAYS    = 4,
    parameter int TAG_W       = 23,
    parameter int CMP_W       = 23,
    parameter int FRAME_BITS  = 16,
    parameter int THREAD_BITS = 8,
    parameter int PAGE_BITS   = 7,
    parameter int ROW_W       = 252
) (
    input  stlb_pkg::stlb_kind_t         kind,
    input  logic [CMP_W-1:0]             tag,
    input  logic [FRAME_BITS-1:0]        frame,
    input  logic [THREAD_BITS-1:0]       thread,
    input  logic [PAGE_BITS-1:0]         offset,
    input  logic [ROW_W-1:0]             row_rd,
    input  logic [NUM_WAYS-1:0]          valid_rd,
    output logic [ROW_W-1:0]             row_wr,
    output logic [NUM_WAYS-1:0]          valid_wr,
    output logic [stlb_pkg::PHYS_W-1:0]  phys,
    output stlb_pkg::stlb_status_t       status
);

    import stlb_pkg::*;

    localparam int WAY_IDX = $clog2(NUM_WAYS);
    localparam int PA_W    = FRAME_BITS + PAGE_BITS;

    logic [NUM_WAYS-1:0][TAG_W-1:0]       rd_tag;
    logic [NUM_WAYS-1:0][FRAME_BITS-1:0]  rd_frame;
    logic [NUM_WAYS-1:0][THREAD_BITS-1:0] rd_owner;
    logic [NUM_WAYS-1:0][AGE_W-1:0]       rd_age;
    logic [NUM_WAYS-1:0][TAG_W-1:0]       wr_tag;
    logic [NUM_WAYS-1:0][FRAME_BITS-1:0]  wr_frame;
    logic [NUM_WAYS-1:0][THREAD_BITS-1:0] wr_owner;
    logic [NUM_WAYS-1:0][AGE_W-1:0]       wr_age;

    assign {rd_tag, rd_frame, rd_owner, rd_age} = row_rd;
    assign row_wr = {wr_tag, wr_frame, wr_owner, wr_age};

    always_comb
    begin
        logic               found;
        logic               stop;
        logic [WAY_IDX-1:0] pick;
        logic [PA_W-1:0]    pa;

        wr_tag   = rd_tag;
        wr_frame = rd_frame;
        wr_owner = rd_owner;
        wr_age   = rd_age;
        valid_wr = valid_rd;
        phys     = '0;
        status   = '0;
        found    = 1'b0;
        stop     = 1'b0;
        pick     = '0;
        pa       = '0;

        case (kind)
            KIND_TRANSLATE:
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (!found && valid_rd[w] && CMP_W'(rd_tag[w]) == tag)
                    begin
                        found         = 1'b1;
                        wr_age[w]     = '0;
                        pa            = {rd_frame[w], offset};
                        phys          = PHYS_W'(pa);
                        status.hit    = 1'b1;
                        status.row_we = 1'b1;
                    end
                end
            end
            KIND_INSERT:
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (!stop)
                    begin
                        if (valid_rd[w])
                        begin
                            if (rd_age[w] != AGE_MAX)
                            begin
                                wr_age[w] = rd_age[w] + AGE_W'(1);
                            end
                            if (wr_age[w] > wr_age[pick])
                            begin
                                pick = WAY_IDX'(w);
                            end
                        end
                        else
                        begin
                            pick = WAY_IDX'(w);
                            stop = 1'b1;
                        end
                    end
                end
                status.replaced = valid_rd[pick];
                status.row_we   = 1'b1;
                wr_tag[pick]    = TAG_W'(tag);
                wr_frame[pick]  = frame;
                wr_owner[pick]  = thread;
                wr_age[pick]    = '0;
                valid_wr[pick]  = 1'b1;
            end
            KIND_INVALIDATE:
            begin
                for (int w = 0; w < NUM_WAYS; w++)
                begin
                    if (valid_rd[w] && CMP_W'(rd_tag[w]) == tag && rd_owner[w] == thread)
                    begin
                        valid_wr[w] = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hdl/set_assoc_tlb_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_tlb_lru
// Set-associative TLB with age-based replacement, one row per set in memory.
// ----------------------------------------------------------------------------
// An accepted request and its set row read are registered; the execute state
// then loads the result register and the registered result strobe. No new
// request is accepted while busy, during the read-modify-write of the row.
// Reset clears all valid bits at once; no clearing pass is needed.
// The receiver cannot stall, so every result is shown for exactly one cycle.
module set_assoc_tlb_lru #(
    parameter int NUM_SETS    = 4,
    parameter int NUM_WAYS    = 4,
    parameter int PAGE_BITS   = 7,
    parameter int ADDR_BITS   = 32,
    parameter int FRAME_BITS  = 16,
    parameter int THREAD_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  stlb_pkg::stlb_req_t request,
    output logic                done,
    output stlb_pkg::stlb_rsp_t result
);

    import stlb_pkg::*;

    `include "assert_macros.svh"

    localparam int SET_BITS = $clog2(NUM_SETS);
    localparam int VPN_W    = ADDR_BITS - PAGE_BITS;
    localparam int TAG_W    = (VPN_W > SET_BITS) ? (VPN_W - SET_BITS) : 1;
    localparam int WIDE_W   = (VPN_W > PNUM_W) ? VPN_W : PNUM_W;
    localparam int CMP_W    = (WIDE_W > SET_BITS) ? (WIDE_W - SET_BITS) : 1;
    localparam int WAY_W    = TAG_W + FRAME_BITS + THREAD_BITS + AGE_W;
    localparam int ROW_W    = NUM_WAYS * WAY_W;

    stlb_state_t                state_reg;
    stlb_state_t                state_next;
    logic                       accept;

    logic [ADDR_BITS-1:0]       addr;
    logic [VPN_W-1:0]           vpn;
    logic [SET_BITS-1:0]        set_in;
    logic [CMP_W-1:0]           tag_in;

    stlb_kind_t                 kind_reg;
    logic [SET_BITS-1:0]        set_reg;
    logic [CMP_W-1:0]           tag_reg;
    logic [FRAME_BITS-1:0]      frame_reg;
    logic [THREAD_BITS-1:0]     thread_reg;
    logic [PAGE_BITS-1:0]       offset_reg;

    logic [NUM_SETS-1:0][NUM_WAYS-1:0] valid_reg;

    logic [ROW_W-1:0]           row_rd;
    logic [ROW_W-1:0]           row_wr;
    logic [NUM_WAYS-1:0]        valid_wr;
    logic [PHYS_W-1:0]          phys;
    stlb_status_t               status;
    logic                       exec;

    logic                       done_reg;
    stlb_rsp_t                  result_reg;

    assign exec   = (state_reg == ST_EXEC);
    assign busy   = exec;
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign addr = ADDR_BITS'(request.virt_addr);
    assign vpn  = VPN_W'(addr >> PAGE_BITS);

    always_comb
    begin
        if (request.kind == KIND_INVALIDATE)
        begin
            set_in = SET_BITS'(request.page_number);
            tag_in = CMP_W'(request.page_number >> SET_BITS);
        end
        else
        begin
            set_in = SET_BITS'(vpn);
            tag_in = CMP_W'(vpn >> SET_BITS);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= exec;
            if (exec)
            begin
                valid_reg[set_reg] <= valid_wr;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg   <= request.kind;
            set_reg    <= set_in;
            tag_reg    <= tag_in;
            frame_reg  <= FRAME_BITS'(request.page_frame);
            thread_reg <= THREAD_BITS'(request.thread_id);
            offset_reg <= PAGE_BITS'(addr);
        end
        if (exec)
        begin
            result_reg.hit       <= status.hit;
            result_reg.phys_addr <= phys;
            result_reg.replaced  <= status.replaced;
        end
    end

    stlb_row_ram #(
        .DEPTH (NUM_SETS),
        .WIDTH (ROW_W)
    ) u_row_ram (
        .clk   (clk),
        .we    (exec && status.row_we),
        .waddr (set_reg),
        .wdata (row_wr),
        .re    (accept),
        .raddr (set_in),
        .rdata (row_rd)
    );

    stlb_set_logic #(
        .NUM_WAYS    (NUM_WAYS),
        .TAG_W       (TAG_W),
        .CMP_W       (CMP_W),
        .FRAME_BITS  (FRAME_BITS),
        .THREAD_BITS (THREAD_BITS),
        .PAGE_BITS   (PAGE_BITS),
        .ROW_W       (ROW_W)
    ) u_set_logic (
        .kind     (kind_reg),
        .tag      (tag_reg),
        .frame    (frame_reg),
        .thread   (thread_reg),
        .offset   (offset_reg),
        .row_rd   (row_rd),
        .valid_rd (valid_reg[set_reg]),
        .row_wr   (row_wr),
        .valid_wr (valid_wr),
        .phys     (phys),
        .status   (status)
    );

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy && !done, "Accepted request did not start.")
    `ASSERT_NEXT(a_exec_done, clk, rst_n, exec, done && !busy, "Executed request gave no result.")
    `ASSERT_IMPLIES(a_miss_zero, clk, rst_n, done && !result.hit, result.phys_addr == '0, "Miss with nonzero address.")
    `ASSERT_IMPLIES(a_hit_repl, clk, rst_n, done, !(result.hit && result.replaced), "Hit and replace together.")

endmodule

FILE: tb/tb_set_assoc_tlb_lru.sv
// ----------------------------------------------------------------------------
// tb_set_assoc_tlb_lru
// Self-checking bench for the 4-set, 4-way TLB. A shadow copy of the entry
// array predicts the response to every accepted request. Stimulus is a short
// directed sequence, a short aging run on one set, and three random phases
// built around a pool of live mappings, with and without sender gaps.
// ----------------------------------------------------------------------------
module tb_set_assoc_tlb_lru;
    import stlb_pkg::*;

    localparam int NUM_SETS    = 4;
    localparam int NUM_WAYS    = 4;
    localparam int SET_BITS    = 2;
    localparam int PAGE_BITS   = 7;
    localparam int TAG_W       = PNUM_W - SET_BITS;
    localparam int IDLE_LIMIT  = 2000;
    localparam int AGE_SOAK    = 40;
    localparam int POOL_DEPTH  = 24;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [PNUM_W-1:0] vpn;
        logic [TID_W-1:0]  owner;
    } mapping_t;

    class tlb_shadow;
        bit                  valid_q[NUM_SETS*NUM_WAYS];
        logic [TAG_W-1:0]    tag_q[NUM_SETS*NUM_WAYS];
        logic [PFRAME_W-1:0] frame_q[NUM_SETS*NUM_WAYS];
        logic [TID_W-1:0]    owner_q[NUM_SETS*NUM_WAYS];
        logic [AGE_W-1:0]    age_q[NUM_SETS*NUM_WAYS];
        stlb_rsp_t           pending_rsp[$];
        int                  errors;

        function new();
            for (int i = 0; i < NUM_SETS*NUM_WAYS; i++)
            begin
                valid_q[i] = 1'b0;
                tag_q[i]   = '0;
                frame_q[i] = '0;
                owner_q[i] = '1;
                age_q[i]   = '0;
            end
            errors = 0;
        endfunction

        function void note_request(stlb_req_t r);
            stlb_rsp_t         rsp;
            logic [PNUM_W-1:0] vpn;
            logic [TAG_W-1:0]  tag;
            int                base;
            int                pick;
            bit                stop;
            rsp = '0;
            vpn = (r.kind == KIND_INVALIDATE) ? r.page_number
                                              : r.virt_addr[VADDR_W-1:PAGE_BITS];
            tag  = vpn[PNUM_W-1:SET_BITS];
            base = int'(vpn[SET_BITS-1:0]) * NUM_WAYS;
            pick = 0;
            stop = 1'b0;
            case (r.kind)
                KIND_TRANSLATE:
                begin
                    for (int w = 0; w < NUM_WAYS; w++)
                    begin
                        if (!stop && valid_q[base+w] && tag_q[base+w] == tag)
                        begin
                            rsp.hit       = 1'b1;
                            rsp.phys_addr = {frame_q[base+w], r.virt_addr[PAGE_BITS-1:0]};
                            age_q[base+w] = '0;
                            stop          = 1'b1;
                        end
                    end
                end
                KIND_INSERT:
                begin
                    for (int w = 0; w < NUM_WAYS; w++)
                    begin
                        if (!stop)
                        begin
                            if (valid_q[base+w])
                            begin
                                if (age_q[base+w] != AGE_MAX)
                                    age_q[base+w] = age_q[base+w] + 1'b1;
                                if (age_q[base+w] > age_q[base+pick])
                                    pick = w;
                            end
                            else
                            begin
                                pick = w;
                                stop = 1'b1;
                            end
                        end
                    end
                    rsp.replaced        = valid_q[base+pick];
                    valid_q[base+pick]  = 1'b1;
                    tag_q[base+pick]    = tag;
                    frame_q[base+pick]  = r.page_frame;
                    owner_q[base+pick]  = r.thread_id;
                    age_q[base+pick]    = '0;
                end
                KIND_INVALIDATE:
                begin
                    for (int w = 0; w < NUM_WAYS; w++)
                    begin
                        if (valid_q[base+w] && tag_q[base+w] == tag
                            && owner_q[base+w] == r.thread_id)
                            valid_q[base+w] = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            pending_rsp.push_back(rsp);
        endfunction

        function void check_result(stlb_rsp_t got);
            stlb_rsp_t want;
            if (pending_rsp.size() == 0)
            begin
                $error("result strobe with no request outstanding");
                errors++;
                return;
            end
            want = pending_rsp.pop_front();
            if (got.hit !== want.hit)
            begin
                $error("hit: expected %0d, actual %0d", want.hit, got.hit);
                errors++;
            end
            if (got.phys_addr !== want.phys_addr)
            begin
                $error("phys_addr: expected 0x%06h, actual 0x%06h",
                       want.phys_addr, got.phys_addr);
                errors++;
            end
            if (got.replaced !== want.replaced)
            begin
                $error("replaced: expected %0d, actual %0d", want.replaced, got.replaced);
                errors++;
            end
        endfunction

        function int pending();
            return pending_rsp.size();
        endfunction
    endclass

    logic      clk = 1'b0;
    logic      rst_n;
    logic      start;
    logic      busy;
    stlb_req_t request;
    logic      done;
    stlb_rsp_t result;

    tlb_shadow board = new();
    mapping_t  mappings[$];
    int        idle_cycles = 0;

    set_assoc_tlb_lru DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
                board.check_result(result);
            if (done || (start && !busy))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < IDLE_LIMIT)
            @(posedge clk);
        $display("set_assoc_tlb_lru: mismatch");
        $finish;
    end

    function automatic logic [PNUM_W-1:0] page(logic [TAG_W-1:0] tag,
                                               logic [SET_BITS-1:0] set_idx);
        return {tag, set_idx};
    endfunction

    function automatic stlb_req_t mk(logic [KIND_W-1:0] k, logic [PNUM_W-1:0] vpn,
                                     logic [PAGE_BITS-1:0] off,
                                     logic [PFRAME_W-1:0] frame,
                                     logic [TID_W-1:0] owner);
        stlb_req_t r;
        r.kind        = stlb_kind_t'(k);
        r.virt_addr   = {vpn, off};
        r.page_frame  = frame;
        r.thread_id   = owner;
        r.page_number = vpn;
        return r;
    endfunction

    task automatic send(stlb_req_t r);
        start   <= 1'b1;
        request <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_request(r);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.pending() != 0);
    endtask

    task automatic run_random(int count, int gap_pct);
        stlb_req_t r;
        mapping_t  m;
        int        roll;
        repeat (count)
        begin
            roll          = $urandom_range(0, 99);
            r.kind        = stlb_kind_t'(2'($urandom));
            r.virt_addr   = $urandom;
            r.page_frame  = 16'($urandom);
            r.thread_id   = 8'($urandom);
            r.page_number = 25'($urandom);
            if (mappings.size() != 0 && $urandom_range(0, 3) != 0)
                m = mappings[$urandom_range(0, mappings.size() - 1)];
            else
            begin
                if ($urandom_range(0, 9) == 0)
                    m.vpn = 25'($urandom);
                else
                    m.vpn = page(23'($urandom_range(0, 15)), 2'($urandom_range(0, 3)));
                m.owner = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                      : 8'($urandom_range(0, 3));
            end
            if (roll >= 8)
            begin
                if (roll < 40)
                begin
                    r.kind = KIND_TRANSLATE;
                    r.virt_addr[VADDR_W-1:PAGE_BITS] = m.vpn;
                end
                else if (roll < 70)
                begin
                    r.kind      = KIND_INSERT;
                    r.thread_id = m.owner;
                    r.virt_addr[VADDR_W-1:PAGE_BITS] = m.vpn;
                    mappings.push_back(m);
                    if (mappings.size() > POOL_DEPTH)
                        void'(mappings.pop_front());
                end
                else if (roll < 94)
                begin
                    r.kind        = KIND_INVALIDATE;
                    r.page_number = m.vpn;
                    r.thread_id   = ($urandom_range(0, 3) != 0) ? m.owner
                                                                : 8'($urandom_range(0, 3));
                end
                else
                    r.kind = stlb_kind_t'(KIND_UNUSED);
            end
            send(r);
            if ($urandom_range(0, 99) < gap_pct)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 5))
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        request = '0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(mk(KIND_TRANSLATE, '0, '0, '0, '0));
        send(mk(KIND_INVALIDATE, '0, '0, '0, '1));
        send(mk(KIND_INSERT, '0, '0, '1, '0));
        send(mk(KIND_TRANSLATE, '0, '1, '0, '0));
        send(mk(KIND_INSERT, '1, '0, '0, '1));
        send(mk(KIND_TRANSLATE, '1, '1, '1, '1));
        send(mk(KIND_INSERT, page(1, 0), 7'h11, 16'h0101, 8'd5));
        send(mk(KIND_INSERT, page(2, 0), 7'h22, 16'h0202, 8'd6));
        send(mk(KIND_INSERT, page(3, 0), 7'h33, 16'h0303, 8'd7));
        send(mk(KIND_INSERT, page(4, 0), 7'h44, 16'h0404, 8'd8));
        send(mk(KIND_TRANSLATE, '0, 7'h40, '0, '0));
        send(mk(KIND_INSERT, page(4, 0), 7'h00, 16'h0444, 8'd8));
        send(mk(KIND_TRANSLATE, page(4, 0), 7'h15, '0, '0));
        send(mk(KIND_INVALIDATE, page(1, 0), '0, '0, 8'd9));
        send(mk(KIND_TRANSLATE, page(1, 0), 7'h2a, '0, '0));
        send(mk(KIND_INVALIDATE, page(1, 0), '0, '0, 8'd5));
        send(mk(KIND_TRANSLATE, page(1, 0), 7'h2a, '0, '0));
        send(mk(KIND_INSERT, page(5, 0), 7'h55, 16'h0505, 8'd3));
        send(mk(KIND_UNUSED, page(5, 0), 7'h55, 16'h0505, 8'd3));
        send(mk(KIND_TRANSLATE, page(5, 0), 7'h01, '0, '0));
        send(mk(KIND_INVALIDATE, '1, '0, '0, '1));
        send(mk(KIND_TRANSLATE, '1, '1, '0, '0));
        drain();

        // Keep way 1 of set 2 cycling so that way 0 keeps aging meanwhile.
        send(mk(KIND_INSERT, page(9, 2), '0, 16'h1234, 8'd1));
        repeat (AGE_SOAK)
        begin
            send(mk(KIND_INSERT, page(10, 2), '0, 16'h0a0a, 8'd2));
            send(mk(KIND_INVALIDATE, page(10, 2), '0, '0, 8'd2));
        end
        send(mk(KIND_INSERT, page(10, 2), '0, 16'h0a0a, 8'd2));
        send(mk(KIND_INSERT, page(11, 2), '0, 16'h0b0b, 8'd2));
        send(mk(KIND_INSERT, page(12, 2), '0, 16'h0c0c, 8'd2));
        send(mk(KIND_INSERT, page(13, 2), '0, 16'h0d0d, 8'd2));
        send(mk(KIND_TRANSLATE, page(9, 2), 7'h05, '0, '0));
        send(mk(KIND_TRANSLATE, page(13, 2), 7'h06, '0, '0));
        drain();

        run_random(530, 26);
        drain();
        run_random(530, 57);
        drain();
        run_random(530, 0);
        drain();
        repeat (4)
            @(posedge clk);

        if (board.errors == 0 && board.pending() == 0)
            $display("set_assoc_tlb_lru: match");
        else
            $display("set_assoc_tlb_lru: mismatch");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hdl
hdl/stlb_pkg.sv
hdl/stlb_row_ram.sv
hdl/stlb_set_logic.sv
hdl/set_assoc_tlb_lru.sv
tb/tb_set_assoc_tlb_lru.sv
